// File: rtl/core/tql_pkg.sv
// Shared types, sizes and codes for the timeout queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tql_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS = 32;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

	// request opcodes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// result kinds
	localparam logic KIND_EXPIRED  = 1'b0;
	localparam logic KIND_REJECTED = 1'b1;

	// commands broadcast along the cell row
	localparam logic [1:0] CH_NOP    = 2'd0;
	localparam logic [1:0] CH_INSERT = 2'd1;
	localparam logic [1:0] CH_POP    = 2'd2;
	localparam logic [1:0] CH_CANCEL = 2'd3;

	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  request_id;
		logic [3:0]  handler_tag;
		logic        deleted;
		logic        newest;
	} entry_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] deadline;
		logic [7:0]  request_id;
		logic [3:0]  handler_tag;
	} chain_cmd_t;

endpackage

// File: rtl/core/timeout_queue_lazy_cancel_top.sv
// Timeout queue top level: request decode, tick scan control and result register.
// Depends on tql_pkg and tql_chain.
`timescale 1ns / 1ps

// Timers sit in a row of 32 cells sorted by deadline, earliest at the front,
// with equal deadlines in arrival order. Each request is taken in the idle
// state and carried out in the execute state: an add shifts the later part
// of the row by one slot to make room, and a cancel marks the matching
// entry in place. A tick then scans, taking entries off the front (expired
// or cancelled) until it sees the end of the scan, and a flush state then
// releases the final result; that scan pops the row's front cell once a
// cycle unless a result waits for the held output register.
// Results stall the scan, and a rejected add, only while the output register
// is still held.
// Entries beyond the fill count are never read, so there is no clearing pass.
// The next request is taken once the previous one is fully done.
module timeout_queue_lazy_cancel_top import tql_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // request_id[7:0], timeout_ms[23:8], handler_tag[27:24], zero
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // expired_request[7:0], expired_handler[11:8], zero
	output logic [0:0]  m_tuser,  // result_kind
	output logic        m_tlast   // last_result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      clock_q;
	logic [N_W-1:0]   n_q;

	// latched request
	logic [1:0]  op_q;
	logic [31:0] dl_q;
	logic [7:0]  id_q;
	logic [3:0]  tag_q;

	// expired entry waiting until we know whether it is the final one
	logic       pend_v_q;
	logic [7:0] pend_id_q;
	logic [3:0] pend_tag_q;

	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] out_id_q;
	logic [3:0] out_tag_q;
	logic       out_last_q;

	chain_cmd_t cmd;
	entry_t     front;
	logic       accept, out_free;
	logic       load_out, take_pend, clear_pend, do_tick;
	logic       out_kind_d, out_last_d;
	logic [7:0] out_id_d;
	logic [3:0] out_tag_d;
	logic [32:0] dl_sum;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign dl_sum   = {1'b0, clock_q} + {17'b0, s_tdata[23:8]};

	always_comb begin
		state_d     = state_q;
		cmd.op      = CH_NOP;
		cmd.deadline    = dl_q;
		cmd.request_id  = id_q;
		cmd.handler_tag = tag_q;
		load_out    = 1'b0;
		take_pend   = 1'b0;
		clear_pend  = 1'b0;
		do_tick     = 1'b0;
		out_kind_d  = KIND_EXPIRED;
		out_id_d    = pend_id_q;
		out_tag_d   = pend_tag_q;
		out_last_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_ADD: begin
						if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							if (out_free) begin
								load_out   = 1'b1;
								out_kind_d = KIND_REJECTED;
								out_id_d   = id_q;
								out_tag_d  = tag_q;
								out_last_d = 1'b1;
								state_d    = ST_IDLE;
							end
						end else begin
							cmd.op  = CH_INSERT;
							state_d = ST_IDLE;
						end
					end
					OP_CANCEL: begin
						cmd.op  = CH_CANCEL;
						state_d = ST_IDLE;
					end
					OP_TICK: begin
						do_tick = 1'b1;
						state_d = ST_SCAN;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				if (count_q == '0 || n_q == N_W'(MAX_RESULTS)) begin
					state_d = ST_FLUSH;
				end else if (front.deleted) begin
					cmd.op = CH_POP;
				end else if (front.deadline > clock_q) begin
					state_d = ST_FLUSH;
				end else if (!pend_v_q) begin
					cmd.op    = CH_POP;
					take_pend = 1'b1;
				end else if (out_free) begin
					cmd.op    = CH_POP;
					take_pend = 1'b1;
					load_out  = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out   = 1'b1;
					out_last_d = 1'b1;
					clear_pend = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			clock_q     <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == CH_INSERT) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.op == CH_POP) begin
				count_q <= count_q - 1'b1;
			end
			if (do_tick) begin
				n_q <= '0;
				if (clock_q != CLOCK_MAX) begin
					clock_q <= clock_q + 1'b1;
				end
			end
			if (take_pend) begin
				n_q      <= n_q + 1'b1;
				pend_v_q <= 1'b1;
			end else if (clear_pend) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			id_q  <= s_tdata[7:0];
			tag_q <= s_tdata[27:24];
			dl_q  <= dl_sum[32] ? CLOCK_MAX : dl_sum[31:0];
		end
		if (take_pend) begin
			pend_id_q  <= front.request_id;
			pend_tag_q <= front.handler_tag;
		end
		if (load_out) begin
			out_kind_q <= out_kind_d;
			out_id_q   <= out_id_d;
			out_tag_q  <= out_tag_d;
			out_last_q <= out_last_d;
		end
	end

	tql_chain u_chain (
		.clk   (clk),
		.cmd   (cmd),
		.count (count_q),
		.front (front)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_tag_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/core/tql_cell.sv
// One slot of the sorted timer row: holds an entry and trades it with its neighbours.
// Depends on tql_pkg.
`timescale 1ns / 1ps

module tql_cell import tql_pkg::*; (
	input  logic       clk,
	input  chain_cmd_t cmd,
	input  logic       occupied,
	input  logic       tail,
	input  entry_t     prev_entry,
	input  logic       prev_gt,
	input  entry_t     next_entry,
	output entry_t     entry_out,
	output logic       gt
);

	entry_t entry_q;
	entry_t fresh;
	logic   id_match;

	always_comb begin
		id_match  = (entry_q.request_id == cmd.request_id);
		gt        = occupied && (entry_q.deadline > cmd.deadline);
		entry_out = entry_q;
		// an add with the same id takes the newest mark away, also from entries in flight
		if (cmd.op == CH_INSERT && id_match) begin
			entry_out.newest = 1'b0;
		end
		fresh.deadline    = cmd.deadline;
		fresh.request_id  = cmd.request_id;
		fresh.handler_tag = cmd.handler_tag;
		fresh.deleted     = 1'b0;
		fresh.newest      = 1'b1;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CH_INSERT: begin
				if (prev_gt) begin
					entry_q <= prev_entry;
				end else if (gt || tail) begin
					entry_q <= fresh;
				end else begin
					entry_q <= entry_out;
				end
			end
			CH_POP: begin
				entry_q <= next_entry;
			end
			CH_CANCEL: begin
				if (occupied && id_match && entry_q.newest) begin
					entry_q.deleted <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/tql_chain.sv
// Row of timer cells kept sorted by deadline, front at cell 0.
// Depends on tql_pkg and tql_cell.
`timescale 1ns / 1ps

module tql_chain import tql_pkg::*; (
	input  logic             clk,
	input  chain_cmd_t       cmd,
	input  logic [CNT_W-1:0] count,
	output entry_t           front
);

	entry_t cell_out [QUEUE_DEPTH];
	logic   cell_gt  [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_g;

		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_out[i-1];
			assign prev_g = cell_gt[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_out[i+1];
		end

		tql_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (CNT_W'(i) < count),
			.tail       (CNT_W'(i) == count),
			.prev_entry (prev_e),
			.prev_gt    (prev_g),
			.next_entry (next_e),
			.entry_out  (cell_out[i]),
			.gt         (cell_gt[i])
		);
	end

	assign front = cell_out[0];

endmodule

// File: rtl/core/tql_checker.sv
// Port-level checks for the timeout queue, bound to the top level.
// Depends on tql_pkg and timeout_queue_lazy_cancel_top.
`timescale 1ns / 1ps

module tql_checker import tql_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// a held result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// one request at a time
	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// a rejection is the only result of its add
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == KIND_REJECTED |-> m_tlast)
		else $error("rejection not marked final");

	// a cancel finishes in its execute cycle
	a_cancel_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_CANCEL |=> !s_tready ##1 s_tready)
		else $error("cancel took too long");

endmodule

bind timeout_queue_lazy_cancel_top tql_checker u_tql_checker (.*);
